// File: src/route_relocate_local_search_assert.svh
// Assertion macros shared by the route relocate search modules.
// Depends on nothing; included by modules that carry assertions.
`ifndef ROUTE_RELOCATE_LOCAL_SEARCH_ASSERT_SVH
`define ROUTE_RELOCATE_LOCAL_SEARCH_ASSERT_SVH
// implication checked every cycle outside reset
`define RRLS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication outside reset
`define RRLS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// File: src/rrls_pkg.sv
// Package for route relocate local search: sizes, codes and shared types.
// Depends on nothing.
package rrls_pkg;
   localparam int MAX_NODES = 64;
   localparam int MAX_ROUTE = 32;
   localparam int DIST_BITS = 16;
   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int SLOT_W = $clog2(MAX_ROUTE);
   localparam int LEN_W = $clog2(MAX_ROUTE + 1);
   localparam int COST_W = DIST_BITS + 3;

   localparam logic [1:0] CMD_DIST = 2'd0;
   localparam logic [1:0] CMD_SLOT = 2'd1;
   localparam logic [1:0] CMD_RUN = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_GAIN, ST_ADD, ST_EVAL, ST_NEXT, ST_DECIDE, ST_MOVE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load_len;    // latch length, clear counters
      logic       sel_gain;    // fetch distances for removal gain
      logic       sel_add;     // fetch distances for insertion cost
      logic       eval;        // compare candidate against best
      logic       step_r;      // advance insert position
      logic       step_c;      // advance removal position, reset insert
      logic       pass_start;  // clear best
      logic       apply;       // apply best move, count it
      logic       set_capped;
      logic       emit_start;
      logic       emit_step;
   } cmd_type;

   typedef struct packed {
      logic r_end;     // insert position past range
      logic c_end;     // removal position past range
      logic skip;      // insert position invalid for this removal
      logic found;
      logic cap_hit;
      logic move_done;
      logic emit_last;
   } status_type;
endpackage

// File: src/rrls_datapath.sv
// Datapath: distance memory, route registers, cost arithmetic, move shifter.
// Depends on rrls_pkg and route_relocate_local_search_assert.svh.
`include "route_relocate_local_search_assert.svh"
module rrls_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         dist_we,
   input  logic [rrls_pkg::NODE_W-1:0]  dist_from,
   input  logic [rrls_pkg::NODE_W-1:0]  dist_to,
   input  logic [rrls_pkg::DIST_BITS-1:0] dist_data,
   input  logic                         slot_we,
   input  logic [rrls_pkg::SLOT_W-1:0]  slot_idx,
   input  logic [5:0]                   slot_data,
   input  logic [5:0]                   run_len,
   input  logic [15:0]                  max_moves,
   input  rrls_pkg::cmd_type            cmd,
   output rrls_pkg::status_type         sts,
   output logic                         apply_end,
   output logic [4:0]                   emit_slot,
   output logic [5:0]                   emit_node,
   output logic [15:0]                  emit_moves,
   output logic                         emit_capped
);
   localparam int CW = rrls_pkg::COST_W;
   localparam int SW = rrls_pkg::SLOT_W;
   localparam int LW = rrls_pkg::LEN_W;

   logic [rrls_pkg::DIST_BITS-1:0] dmem [rrls_pkg::MAX_NODES*rrls_pkg::MAX_NODES];
   logic [5:0] route_ff [rrls_pkg::MAX_ROUTE];
   logic [LW-1:0] len_ff;
   logic [LW:0] c_ff, r_ff, bc_ff, br_ff;
   logic signed [CW-1:0] gain_ff, best_ff;
   logic found_ff;
   logic [15:0] moves_ff;
   logic capped_ff;
   logic [1:0] ph_ff;
   logic [LW:0] mv_ff;
   logic [rrls_pkg::DIST_BITS-1:0] d_ff;
   logic signed [CW-1:0] acc_ff;
   logic [SW-1:0] e_ff;
   logic [2*rrls_pkg::NODE_W-1:0] raddr;
   logic [5:0] na, nb;
   logic [LW-1:0] len_in;
   logic signed [CW-1:0] d_ext;
   logic [LW:0] at_pos;
   logic [LW:0] cur_pos;

   always_comb begin
      if (run_len > 6'(rrls_pkg::MAX_ROUTE)) begin
         len_in = LW'(rrls_pkg::MAX_ROUTE);
      end else if (run_len == 6'd0) begin
         len_in = LW'(1);
      end else begin
         len_in = LW'(run_len);
      end
   end

   // address pair for the current phase (gain: 0 a-b, 1 a-x, 2 x-b; add: 0 a-x, 1 x-b, 2 a-b)
   always_comb begin
      na = 6'd0;
      nb = 6'd0;
      if (cmd.sel_gain) begin
         case (ph_ff)
            2'd0: begin na = route_ff[SW'(c_ff-1)]; nb = route_ff[SW'(c_ff+1)]; end
            2'd1: begin na = route_ff[SW'(c_ff-1)]; nb = route_ff[SW'(c_ff)]; end
            2'd2: begin na = route_ff[SW'(c_ff)]; nb = route_ff[SW'(c_ff+1)]; end
            default: ;
         endcase
      end else begin
         case (ph_ff)
            2'd0: begin na = route_ff[SW'(r_ff)]; nb = route_ff[SW'(c_ff)]; end
            2'd1: begin na = route_ff[SW'(c_ff)]; nb = route_ff[SW'(r_ff+1)]; end
            2'd2: begin na = route_ff[SW'(r_ff)]; nb = route_ff[SW'(r_ff+1)]; end
            default: ;
         endcase
      end
      raddr = {na[rrls_pkg::NODE_W-1:0], nb[rrls_pkg::NODE_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dmem[{dist_from, dist_to}] <= dist_data;
      end
      d_ff <= dmem[raddr];
   end

   assign d_ext = CW'(d_ff);

   // phase counter: 3 reads issued, then a last phase to take the last datum
   always_ff @(posedge clock) begin
      if (reset || !(cmd.sel_gain || cmd.sel_add) || ph_ff == 2'd3) begin
         ph_ff <= 2'd0;
      end else begin
         ph_ff <= ph_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sel_gain || cmd.sel_add) begin
         case (ph_ff)
            2'd1: acc_ff <= cmd.sel_gain ? d_ext : d_ext;
            2'd2: acc_ff <= cmd.sel_gain ? acc_ff - d_ext : acc_ff + d_ext;
            2'd3: acc_ff <= acc_ff - d_ext;
            default: acc_ff <= acc_ff;
         endcase
      end
      if (cmd.sel_gain && ph_ff == 2'd3) begin
         gain_ff <= acc_ff - d_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         moves_ff <= '0;
         capped_ff <= 1'b0;
         c_ff <= '0;
         r_ff <= '0;
         len_ff <= '0;
         e_ff <= '0;
         mv_ff <= '0;
      end else begin
         if (cmd.load_len) begin
            len_ff <= len_in;
            moves_ff <= '0;
            capped_ff <= 1'b0;
            found_ff <= 1'b0;
         end
         if (cmd.pass_start) begin
            found_ff <= 1'b0;
            best_ff <= '0;
            c_ff <= (LW+1)'(1);
            r_ff <= (LW+1)'(1);
         end
         if (cmd.eval && (acc_ff + gain_ff < best_ff)) begin
            best_ff <= acc_ff + gain_ff;
            bc_ff <= c_ff;
            br_ff <= r_ff;
            found_ff <= 1'b1;
         end
         if (cmd.step_r) begin
            r_ff <= r_ff + 1'b1;
         end
         if (cmd.step_c) begin
            c_ff <= c_ff + 1'b1;
            r_ff <= (LW+1)'(1);
         end
         if (cmd.apply && cur_pos != at_pos) begin
            mv_ff <= mv_ff + 1'b1;
         end else begin
            mv_ff <= '0;
         end
         if (cmd.apply && mv_ff == '0) begin
            moves_ff <= moves_ff + 16'd1;
         end
         if (cmd.set_capped) begin
            capped_ff <= 1'b1;
         end
         if (cmd.emit_start) begin
            e_ff <= '0;
         end else if (cmd.emit_step) begin
            e_ff <= e_ff + 1'b1;
         end
      end
   end

   // relocate: one adjacent swap per cycle moves the node from bc toward its target
   assign at_pos = (bc_ff < br_ff) ? br_ff : br_ff + 1'b1;
   assign cur_pos = (bc_ff < at_pos) ? bc_ff + mv_ff : bc_ff - mv_ff;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         route_ff[slot_idx] <= slot_data;
      end else if (cmd.apply && cur_pos != at_pos) begin
         if (bc_ff < at_pos) begin
            route_ff[SW'(cur_pos)] <= route_ff[SW'(cur_pos+1)];
            route_ff[SW'(cur_pos+1)] <= route_ff[SW'(cur_pos)];
         end else begin
            route_ff[SW'(cur_pos)] <= route_ff[SW'(cur_pos-1)];
            route_ff[SW'(cur_pos-1)] <= route_ff[SW'(cur_pos)];
         end
      end
   end

   always_comb begin
      sts.r_end = (r_ff + 1'b1 >= (LW+1)'(len_ff));
      sts.c_end = (c_ff + 1'b1 >= (LW+1)'(len_ff));
      sts.skip = (r_ff == c_ff) || (r_ff + 1'b1 == c_ff);
      sts.found = found_ff;
      sts.cap_hit = (moves_ff >= max_moves);
      sts.move_done = (ph_ff == 2'd3);
      sts.emit_last = ((LW+1)'(e_ff) + 1'b1 >= (LW+1)'(len_ff));
   end

   assign apply_end = cmd.apply && (cur_pos == at_pos);

   assign emit_slot = 5'(e_ff);
   assign emit_node = route_ff[e_ff];
   assign emit_moves = moves_ff;
   assign emit_capped = capped_ff;

   // apply ends within the route span
   `RRLS_ASSERT_IMP(a_apply_in_range, clock, reset, cmd.apply,
      cur_pos < (LW+1)'(len_ff))
   `RRLS_ASSERT_IMP(a_no_move_short, clock, reset, found_ff,
      len_ff >= LW'(3))
   `RRLS_ASSERT_NXT(a_apply_end, clock, reset, apply_end, mv_ff == '0)
endmodule

// File: src/rrls_ctrl.sv
// Controller FSM: sequences passes, candidate evaluation, moves and emission.
// Depends on rrls_pkg and route_relocate_local_search_assert.svh.
`include "route_relocate_local_search_assert.svh"
module rrls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 run_go,
   input  rrls_pkg::status_type sts,
   input  logic                 rsp_ready,
   input  logic                 apply_end,
   output rrls_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   rrls_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         rrls_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (run_go) begin
               cmd.load_len = 1'b1;
               state_in = rrls_pkg::ST_NEXT;
            end
         end
         rrls_pkg::ST_NEXT: begin
            cmd.pass_start = 1'b1;
            state_in = rrls_pkg::ST_GAIN;
         end
         rrls_pkg::ST_GAIN: begin
            if (sts.c_end) begin
               state_in = rrls_pkg::ST_DECIDE;
            end else begin
               cmd.sel_gain = 1'b1;
               if (sts.move_done) begin
                  state_in = rrls_pkg::ST_ADD;
               end
            end
         end
         rrls_pkg::ST_ADD: begin
            if (sts.r_end) begin
               cmd.step_c = 1'b1;
               state_in = rrls_pkg::ST_GAIN;
            end else if (sts.skip) begin
               cmd.step_r = 1'b1;
            end else begin
               cmd.sel_add = 1'b1;
               if (sts.move_done) begin
                  state_in = rrls_pkg::ST_EVAL;
               end
            end
         end
         rrls_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            cmd.step_r = 1'b1;
            state_in = rrls_pkg::ST_ADD;
         end
         rrls_pkg::ST_DECIDE: begin
            if (!sts.found) begin
               cmd.emit_start = 1'b1;
               state_in = rrls_pkg::ST_EMIT;
            end else if (sts.cap_hit) begin
               cmd.set_capped = 1'b1;
               cmd.emit_start = 1'b1;
               state_in = rrls_pkg::ST_EMIT;
            end else begin
               state_in = rrls_pkg::ST_MOVE;
            end
         end
         rrls_pkg::ST_MOVE: begin
            cmd.apply = 1'b1;
            if (apply_end) begin
               state_in = rrls_pkg::ST_NEXT;
            end
         end
         rrls_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_step = 1'b1;
               if (sts.emit_last) begin
                  state_in = rrls_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = rrls_pkg::ST_IDLE;
      endcase
   end

   `RRLS_ASSERT_IMP(a_emit_valid, clock, reset,
      state_ff == rrls_pkg::ST_EMIT, rsp_valid)
   `RRLS_ASSERT_IMP(a_idle_free, clock, reset, !busy, !rsp_valid)
   `RRLS_ASSERT_NXT(a_emit_done, clock, reset,
      rsp_valid && rsp_ready && sts.emit_last, state_ff == rrls_pkg::ST_IDLE)
endmodule

// File: src/route_relocate_local_search.sv
// Top level of the intra-route relocate local search block.
// Depends on rrls_pkg, rrls_ctrl and rrls_datapath.
//
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  cmd, nodes, distance, slot, length
// rsp      out        rsp_valid/rsp_ready  out_slot, out_node, last, moves, capped
// csr      in         csr_we               max_moves
//
// Load requests are accepted back to back while the block is idle.
// A run repeats passes, each paced by the one read port of the distance
// memory, applies each best move by adjacent swaps, then emits L results;
// req_ready is low from run until the last result is taken.
// Reset is synchronous; the memories hold no reset value.
module route_relocate_local_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_from_node,
   input  logic [5:0]  req_to_node,
   input  logic [15:0] req_distance,
   input  logic [4:0]  req_slot,
   input  logic [5:0]  req_slot_node,
   input  logic [5:0]  req_route_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_out_slot,
   output logic [5:0]  rsp_out_node,
   output logic        rsp_last,
   output logic [15:0] rsp_moves_made,
   output logic        rsp_capped,
   input  logic        csr_we,
   input  logic [15:0] csr_max_moves
);
   logic [15:0] max_moves_ff;
   logic busy;
   logic acc;
   logic apply_end;
   rrls_pkg::cmd_type cmd;
   rrls_pkg::status_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_moves_ff <= 16'd4096;
      end else if (csr_we) begin
         max_moves_ff <= csr_max_moves;
      end
   end

   assign req_ready = !busy;
   assign acc = req_valid && req_ready;

   rrls_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .run_go(acc && req_cmd == rrls_pkg::CMD_RUN),
      .sts(sts), .rsp_ready(rsp_ready), .apply_end(apply_end),
      .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid)
   );

   rrls_datapath u_dp (
      .clock(clock), .reset(reset),
      .dist_we(acc && req_cmd == rrls_pkg::CMD_DIST),
      .dist_from(req_from_node), .dist_to(req_to_node), .dist_data(req_distance),
      .slot_we(acc && req_cmd == rrls_pkg::CMD_SLOT),
      .slot_idx(req_slot), .slot_data(req_slot_node),
      .run_len(req_route_length), .max_moves(max_moves_ff),
      .cmd(cmd), .sts(sts), .apply_end(apply_end),
      .emit_slot(rsp_out_slot), .emit_node(rsp_out_node),
      .emit_moves(rsp_moves_made), .emit_capped(rsp_capped)
   );

   assign rsp_last = sts.emit_last;
endmodule

// File: sim/tb_route_relocate_local_search.sv
// Testbench for route_relocate_local_search: loads distance tables and routes,
// runs the relocate search and checks every emitted route position.
// Depends on rrls_pkg and the route_relocate_local_search RTL.
`timescale 1ns / 1ps

class route_scoreboard;
   typedef struct {
      bit [4:0]  slot;
      bit [5:0]  node;
      bit        last;
      bit [15:0] moves;
      bit        capped;
   } route_pos_type;

   bit [15:0]  dist_mem [rrls_pkg::MAX_NODES*rrls_pkg::MAX_NODES];
   bit [5:0]   route_mem [rrls_pkg::MAX_ROUTE];
   bit [15:0]  move_cap;
   route_pos_type route_due_q[$];
   int         errors;
   int         positions_checked;
   int         runs_seen;

   function new();
      move_cap = 16'd4096;
   endfunction

   function void set_cap(bit [15:0] v);
      move_cap = v;
   endfunction

   function longint hop(bit [5:0] a, bit [5:0] b);
      return longint'(dist_mem[int'(a) * rrls_pkg::MAX_NODES + int'(b)]);
   endfunction

   function bit find_best(int len, output int bc, output int br);
      longint best, gain, add;
      bit     found;
      best = 0;
      found = 0;
      bc = 0;
      br = 0;
      for (int c = 1; c < len - 1; c++) begin
         gain = hop(route_mem[c-1], route_mem[c+1]) - hop(route_mem[c-1], route_mem[c])
                - hop(route_mem[c], route_mem[c+1]);
         for (int r = 1; r < len - 1; r++) begin
            if (r != c && r != c - 1) begin
               add = hop(route_mem[r], route_mem[c]) + hop(route_mem[c], route_mem[r+1])
                     - hop(route_mem[r], route_mem[r+1]);
               if (add + gain < best) begin
                  best = add + gain;
                  bc = c;
                  br = r;
                  found = 1;
               end
            end
         end
      end
      return found;
   endfunction

   function void relocate(int len, int c, int r);
      bit [5:0] tmp [rrls_pkg::MAX_ROUTE+1];
      bit [5:0] moved;
      int       n, at;
      moved = route_mem[c];
      n = 0;
      for (int i = 0; i < len; i++) begin
         if (i != c) begin
            tmp[n] = route_mem[i];
            n++;
         end
      end
      at = (c < r) ? r : r + 1;
      for (int i = n; i > at; i--) tmp[i] = tmp[i-1];
      tmp[at] = moved;
      for (int i = 0; i < len; i++) route_mem[i] = tmp[i];
   endfunction

   function void note_request(bit [1:0] cmd, bit [5:0] from_node, bit [5:0] to_node,
                              bit [15:0] distance, bit [4:0] slot, bit [5:0] slot_node,
                              bit [5:0] route_length);
      int         len, moves, bc, br;
      bit         capped;
      route_pos_type p;
      case (cmd)
         rrls_pkg::CMD_DIST:
            dist_mem[int'(from_node) * rrls_pkg::MAX_NODES + int'(to_node)] = distance;
         rrls_pkg::CMD_SLOT: route_mem[slot] = slot_node;
         rrls_pkg::CMD_RUN: begin
            len = int'(route_length);
            if (len > rrls_pkg::MAX_ROUTE) len = rrls_pkg::MAX_ROUTE;
            if (len < 1) len = 1;
            moves = 0;
            capped = 0;
            while (find_best(len, bc, br)) begin
               if (moves >= int'(move_cap)) begin
                  capped = 1;
                  break;
               end
               relocate(len, bc, br);
               moves++;
            end
            for (int k = 0; k < len; k++) begin
               p.slot = 5'(k);
               p.node = route_mem[k];
               p.last = (k == len - 1);
               p.moves = 16'(moves);
               p.capped = capped;
               route_due_q.push_back(p);
            end
            runs_seen++;
         end
         default: ;
      endcase
   endfunction

   function void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_result(bit [4:0] slot, bit [5:0] node, bit last, bit [15:0] moves,
                              bit capped);
      route_pos_type p;
      if (route_due_q.size() == 0) begin
         $display("%0t: unexpected result slot %0d node %0d", $time, slot, node);
         errors++;
         return;
      end
      p = route_due_q.pop_front();
      check_field("out_slot", int'(p.slot), int'(slot));
      check_field("out_node", int'(p.node), int'(node));
      check_field("last", int'(p.last), int'(last));
      check_field("moves_made", int'(p.moves), int'(moves));
      check_field("capped", int'(p.capped), int'(capped));
      positions_checked++;
   endfunction

   function int pending();
      return route_due_q.size();
   endfunction
endclass

module tb_route_relocate_local_search;
   localparam logic [1:0] CMD_NONE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [5:0]  req_from_node;
   logic [5:0]  req_to_node;
   logic [15:0] req_distance;
   logic [4:0]  req_slot;
   logic [5:0]  req_slot_node;
   logic [5:0]  req_route_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [4:0]  rsp_out_slot;
   logic [5:0]  rsp_out_node;
   logic        rsp_last;
   logic [15:0] rsp_moves_made;
   logic        rsp_capped;
   logic        csr_we;
   logic [15:0] csr_max_moves;

   route_scoreboard sb;
   bit  no_gaps;
   bit  hold_rsp;
   int  requests_sent;

   route_relocate_local_search u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_from_node(req_from_node), .req_to_node(req_to_node),
      .req_distance(req_distance), .req_slot(req_slot), .req_slot_node(req_slot_node),
      .req_route_length(req_route_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_slot(rsp_out_slot),
      .rsp_out_node(rsp_out_node), .rsp_last(rsp_last), .rsp_moves_made(rsp_moves_made),
      .rsp_capped(rsp_capped), .csr_we(csr_we), .csr_max_moves(csr_max_moves)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_cmd, req_from_node, req_to_node, req_distance, req_slot,
                            req_slot_node, req_route_length);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_out_slot, rsp_out_node, rsp_last, rsp_moves_made, rsp_capped);
      end
   end

   // receiver: random stall per result, one long hold on request
   initial begin
      int w;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         w = no_gaps ? 0 : $urandom_range(0, 5);
         if (w > 0) begin
            rsp_ready = 0;
            repeat (w) @(negedge clock);
         end
         rsp_ready = 1;
         do @(posedge clock); while (!rsp_valid && !hold_rsp);
      end
   end

   task automatic send(bit [1:0] cmd, bit [5:0] from_node, bit [5:0] to_node,
                       bit [15:0] distance, bit [4:0] slot, bit [5:0] slot_node,
                       bit [5:0] route_length);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_cmd = cmd;
      req_from_node = from_node;
      req_to_node = to_node;
      req_distance = distance;
      req_slot = slot;
      req_slot_node = slot_node;
      req_route_length = route_length;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic put_dist(bit [5:0] a, bit [5:0] b, bit [15:0] d);
      send(rrls_pkg::CMD_DIST, a, b, d, 5'($urandom), 6'($urandom), 6'($urandom));
   endtask

   task automatic put_slot(bit [4:0] s, bit [5:0] n);
      send(rrls_pkg::CMD_SLOT, 6'($urandom), 6'($urandom), 16'($urandom), s, n,
           6'($urandom));
   endtask

   task automatic run_route(bit [5:0] len);
      send(rrls_pkg::CMD_RUN, 6'($urandom), 6'($urandom), 16'($urandom), 5'($urandom),
           6'($urandom), len);
   endtask

   task automatic set_cap(bit [15:0] v);
      req_valid = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      csr_we = 1;
      csr_max_moves = v;
      @(negedge clock);
      csr_we = 0;
      sb.set_cap(v);
   endtask

   initial begin
      bit [5:0]  ids [8];
      bit [15:0] caps [7];
      int        n, len, eff, mode, phase;
      bit        dup;
      sb = new();
      reset = 1;
      req_valid = 0;
      req_cmd = CMD_NONE;
      req_from_node = 0;
      req_to_node = 0;
      req_distance = 0;
      req_slot = 0;
      req_slot_node = 0;
      req_route_length = 0;
      csr_we = 0;
      csr_max_moves = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extreme nodes and distances, short and degenerate lengths
      ids[0] = 6'd0; ids[1] = 6'd63; ids[2] = 6'd42;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            put_dist(ids[a], ids[b], (a == b) ? 16'd0 : ((a + b == 3) ? 16'hFFFF : 16'd1));
      put_slot(5'd0, 6'd0);
      put_slot(5'd1, 6'd63);
      put_slot(5'd2, 6'd42);
      put_slot(5'd3, 6'd63);
      put_slot(5'd4, 6'd0);
      run_route(6'd0);
      run_route(6'd2);
      run_route(6'd5);
      send(CMD_NONE, 6'h3F, 6'h3F, 16'hFFFF, 5'h1F, 6'h3F, 6'h3F);
      run_route(6'd1);

      caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4096, 16'hFFFF, 16'd1};
      phase = 0;
      while (requests_sent < 340) begin
         set_cap((phase % 3 == 2) ? 16'($urandom) : caps[$urandom_range(0, 6)]);
         no_gaps = (phase % 4 == 1);
         n = $urandom_range(3, 6);
         for (int i = 0; i < n; i++) begin
            do begin
               ids[i] = 6'($urandom_range(0, 63));
               dup = 0;
               for (int j = 0; j < i; j++) if (ids[j] == ids[i]) dup = 1;
            end while (dup);
         end
         mode = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0: len = $urandom_range(0, 2);
            1: len = $urandom_range(33, 63);
            2: len = 32;
            default: len = $urandom_range(3, 12);
         endcase
         eff = (len > rrls_pkg::MAX_ROUTE) ? rrls_pkg::MAX_ROUTE : ((len < 1) ? 1 : len);
         // drop a little noise first, then the well-formed load and run, then more noise
         send(CMD_NONE, 6'($urandom), 6'($urandom), 16'($urandom), 5'($urandom),
              6'($urandom), 6'($urandom));
         put_slot(5'($urandom), 6'($urandom));
         put_dist(6'($urandom), 6'($urandom), 16'($urandom));
         for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++)
               case (mode)
                  0: put_dist(ids[a], ids[b], 16'($urandom));
                  1: put_dist(ids[a], ids[b], $urandom_range(0, 1) ? 16'hFFFF : 16'd0);
                  default: put_dist(ids[a], ids[b], 16'($urandom_range(0, 60)));
               endcase
         for (int s = 0; s < eff; s++) put_slot(5'(s), ids[$urandom_range(0, n - 1)]);
         if (phase == 2) hold_rsp = 1;
         run_route(6'(len));
         put_dist(6'($urandom), 6'($urandom), 16'($urandom));
         send(CMD_NONE, 6'($urandom), 6'($urandom), 16'($urandom), 5'($urandom),
              6'($urandom), 6'($urandom));
         phase++;
      end
      req_valid = 0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d requests over %0d runs; %0d route positions compared.",
               requests_sent, sb.runs_seen, sb.positions_checked);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// File: route_relocate_local_search.f
+incdir+src
src/rrls_pkg.sv
src/rrls_datapath.sv
src/rrls_ctrl.sv
src/route_relocate_local_search.sv
sim/tb_route_relocate_local_search.sv
